FILE: rtl/sdfq_pkg.sv
// shared types and constants for the signed distance grid query block
// no dependencies; imported by sdfq_core, sdf_grid_bilinear_query, sdfq_checker and testbench
package sdfq_pkg;

    localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [2:0] REG_INV_CELL  = 3'd2;
    localparam logic [2:0] REG_CLEARANCE = 3'd3;
    localparam logic [2:0] REG_GRID_ROWS = 3'd4;
    localparam logic [2:0] REG_GRID_COLS = 3'd5;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic [31:0]        inv_cell_size;
        logic signed [31:0] clearance;
        logic [6:0]         grid_rows;
        logic [6:0]         grid_cols;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] distance_value;
        logic signed [31:0] gradient_x;
        logic signed [31:0] gradient_y;
        logic               is_safe;
        logic [30:0]        penalty;
        logic signed [31:0] penalty_grad_x;
        logic signed [31:0] penalty_grad_y;
        logic               grid_empty;
    } t_res;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        if (v > 68'sh0_0000_0000_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -68'sh0_0000_0000_8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

FILE: rtl/sdf_grid_bilinear_query.sv
// top level: stream ports, configuration registers, output register
// depends on sdfq_pkg, sdfq_store and sdfq_core
//
// channel   dir  beat contents
// s_axis    in   one cell write or one point query
// m_axis    out  one result per query, none per write
// cfg       in   register index and value, one write per cycle
//
// a cell write goes straight into the grid memory; a query steps through the
// shared multiply sequencer and reads four grid cells through one read port
// reset is synchronous; the grid memory is not cleared
// s_axis_tready is low while a query is in progress; a finished result
// waits in the output register while the next beat is taken
module sdf_grid_bilinear_query #(
    parameter int MAX_CELLS   = 4096,
    parameter int VALUE_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cell_index[11:0], cell_value[43:12], point_x[75:44], point_y[107:76]
    input  logic [111:0] s_axis_tdata,
    // command[0]
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // distance_value[31:0], gradient_x[63:32], gradient_y[95:64], is_safe[96],
    // penalty[127:97], penalty_grad_x[159:128], penalty_grad_y[191:160]
    output logic [191:0] m_axis_tdata,
    // grid_empty[0]
    output logic         m_axis_tuser,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_wdata
);
    import sdfq_pkg::*;

    localparam int AW = $clog2(MAX_CELLS);

    t_cfg         r_cfg;
    logic         r_loaded;
    logic         r_out_valid;
    t_res         r_out;
    logic         w_accept;
    logic         w_we;
    logic         w_start;
    logic         w_busy;
    logic         w_done;
    logic         w_take;
    t_res         w_res;
    logic         w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic signed [31:0] w_rd_data;
    logic [11:0]  w_index;

    assign w_index  = s_axis_tdata[11:0];
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_we     = w_accept && (s_axis_tuser == CMD_WRITE)
                      && (34'(w_index) < 34'(MAX_CELLS));
    assign w_start  = w_accept && (s_axis_tuser == CMD_QUERY);
    assign w_take   = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !w_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x      <= '0;
            r_cfg.origin_y      <= '0;
            r_cfg.inv_cell_size <= 32'h0001_0000;
            r_cfg.clearance     <= '0;
            r_cfg.grid_rows     <= 7'd64;
            r_cfg.grid_cols     <= 7'd64;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_ORIGIN_X:  r_cfg.origin_x      <= i_cfg_wdata;
                REG_ORIGIN_Y:  r_cfg.origin_y      <= i_cfg_wdata;
                REG_INV_CELL:  r_cfg.inv_cell_size <= i_cfg_wdata;
                REG_CLEARANCE: r_cfg.clearance     <= i_cfg_wdata;
                REG_GRID_ROWS: r_cfg.grid_rows     <= i_cfg_wdata[6:0];
                REG_GRID_COLS: r_cfg.grid_cols     <= i_cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_we) begin
                r_loaded <= 1'b1;
            end
            if (w_done && w_take) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done && w_take) begin
            r_out <= w_res;
        end
    end

    sdfq_store #(
        .MAX_CELLS   (MAX_CELLS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(w_index)),
        .i_wdata (s_axis_tdata[43:12]),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    sdfq_core #(
        .MAX_CELLS (MAX_CELLS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_empty   (!r_loaded),
        .i_px      (s_axis_tdata[75:44]),
        .i_py      (s_axis_tdata[107:76]),
        .i_cfg     (r_cfg),
        .o_busy    (w_busy),
        .o_done    (w_done),
        .i_take    (w_take),
        .o_res     (w_res),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.penalty_grad_y, r_out.penalty_grad_x, r_out.penalty,
                            r_out.is_safe, r_out.gradient_y, r_out.gradient_x,
                            r_out.distance_value};
    assign m_axis_tuser  = r_out.grid_empty;
endmodule

FILE: rtl/sdfq_store.sv
// distance grid memory: one write port, one registered read port
// no dependencies
module sdfq_store #(
    parameter int MAX_CELLS   = 4096,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(MAX_CELLS)-1:0] i_waddr,
    input  logic [31:0]                  i_wdata,
    input  logic                         i_re,
    input  logic [$clog2(MAX_CELLS)-1:0] i_raddr,
    output logic signed [31:0]           o_rdata
);
    localparam int SW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

    logic [SW-1:0]        r_mem [MAX_CELLS];
    logic signed [SW-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata[SW-1:0];
        end
        if (i_re) begin
            r_rd <= r_mem[i_raddr];
        end
    end

    assign o_rdata = 32'(r_rd);
endmodule

FILE: rtl/sdfq_core.sv
// query sequencer: coordinate mapping, four cell reads, shared multiplier
// depends on sdfq_pkg; reads the grid through sdfq_store
module sdfq_core #(
    parameter int MAX_CELLS = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_empty,
    input  logic signed [31:0]           i_px,
    input  logic signed [31:0]           i_py,
    input  sdfq_pkg::t_cfg               i_cfg,
    output logic                         o_busy,
    output logic                         o_done,
    input  logic                         i_take,
    output sdfq_pkg::t_res               o_res,
    output logic                         o_rd_en,
    output logic [$clog2(MAX_CELLS)-1:0] o_rd_addr,
    input  logic signed [31:0]           i_rd_data
);
    import sdfq_pkg::*;

    localparam int AW = $clog2(MAX_CELLS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam logic [4:0] OP_FX   = 5'd0;
    localparam logic [4:0] OP_FY   = 5'd1;
    localparam logic [4:0] OP_IDX  = 5'd2;
    localparam logic [4:0] OP_DIF  = 5'd3;
    localparam logic [4:0] OP_TXY  = 5'd4;
    localparam logic [4:0] OP_Q1   = 5'd5;
    localparam logic [4:0] OP_Q2   = 5'd6;
    localparam logic [4:0] OP_Q3   = 5'd7;
    localparam logic [4:0] OP_MIXX = 5'd8;
    localparam logic [4:0] OP_MIXY = 5'd9;
    localparam logic [4:0] OP_VAL  = 5'd10;
    localparam logic [4:0] OP_GX   = 5'd11;
    localparam logic [4:0] OP_GY   = 5'd12;
    localparam logic [4:0] OP_S    = 5'd13;
    localparam logic [4:0] OP_PEN  = 5'd14;
    localparam logic [4:0] OP_PGX  = 5'd15;
    localparam logic [4:0] OP_PGY  = 5'd16;

    function automatic logic [6:0] clamp_idx(input logic signed [26:0] v,
                                              input logic [6:0] n);
        logic [6:0] hi;
        hi = (n == 7'd0) ? 7'd0 : n - 7'd1;
        if (v < 0) begin
            return 7'd0;
        end else if (v > $signed({20'd0, hi})) begin
            return hi;
        end
        return v[6:0];
    endfunction

    function automatic logic [AW-1:0] wrap_addr(input logic [13:0] a);
        logic [33:0] v;
        logic [33:0] m;
        v = 34'(a);
        for (int k = 13; k >= 0; k--) begin
            m = 34'(MAX_CELLS) << k;
            if (v >= m) begin
                v = v - m;
            end
        end
        return v[AW-1:0];
    endfunction

    logic [1:0] r_state;
    logic [4:0] r_op;
    logic       r_wb;
    logic [2:0] r_rcnt;
    logic       r_rph;
    logic       r_empty;

    logic signed [32:0] r_dx, r_dy;
    logic signed [41:0] r_fx, r_fy;
    logic [15:0]        r_tx, r_ty;
    logic [6:0]         r_x0, r_x1, r_y0, r_y1;
    logic [13:0]        r_raw;
    logic signed [31:0] r_v00, r_v01, r_v10, r_v11;
    logic signed [32:0] r_d0, r_e0;
    logic signed [33:0] r_dd;
    logic [31:0]        r_txy;
    logic signed [48:0] r_q1, r_q2;
    logic signed [65:0] r_q3;
    logic signed [33:0] r_mixx, r_mixy;
    logic signed [31:0] r_val, r_gx, r_gy, r_pgx, r_pgy;
    logic signed [32:0] r_s;
    logic               r_safe;
    logic [30:0]        r_pen;
    logic signed [67:0] r_prod;

    logic signed [33:0] m_a, m_b;
    logic signed [67:0] w_q16;
    logic signed [41:0] w_cap;
    logic signed [71:0] w_sum;
    logic [32:0]        w_mag;
    logic [31:0]        w_p32;
    logic [6:0]         w_cols;
    logic [6:0]         w_row, w_col;

    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_op)
            OP_FX:   begin m_a = 34'(r_dx); m_b = $signed({2'b00, i_cfg.inv_cell_size}); end
            OP_FY:   begin m_a = 34'(r_dy); m_b = $signed({2'b00, i_cfg.inv_cell_size}); end
            OP_TXY:  begin m_a = $signed({18'd0, r_tx}); m_b = $signed({18'd0, r_ty}); end
            OP_Q1:   begin m_a = $signed({18'd0, r_tx}); m_b = 34'(r_d0); end
            OP_Q2:   begin m_a = $signed({18'd0, r_ty}); m_b = 34'(r_e0); end
            OP_Q3:   begin m_a = $signed({2'b00, r_txy}); m_b = r_dd; end
            OP_MIXX: begin m_a = $signed({18'd0, r_ty}); m_b = r_dd; end
            OP_MIXY: begin m_a = $signed({18'd0, r_tx}); m_b = r_dd; end
            OP_GX:   begin m_a = r_mixx; m_b = $signed({2'b00, i_cfg.inv_cell_size}); end
            OP_GY:   begin m_a = r_mixy; m_b = $signed({2'b00, i_cfg.inv_cell_size}); end
            OP_PEN:  begin m_a = 34'(r_s); m_b = 34'(r_s); end
            OP_PGX:  begin m_a = 34'(r_s); m_b = 34'(r_gx); end
            OP_PGY:  begin m_a = 34'(r_s); m_b = 34'(r_gy); end
            default: begin m_a = '0; m_b = '0; end
        endcase
    end

    // coordinate magnitude capped at 2^40 before the half-cell offset
    assign w_q16 = r_prod >>> 16;
    always_comb begin
        if (w_q16 > 68'sh0_0000_0100_0000_0000) begin
            w_cap = 42'sh100_0000_0000;
        end else if (w_q16 < -68'sh0_0000_0100_0000_0000) begin
            w_cap = -42'sh100_0000_0000;
        end else begin
            w_cap = w_q16[41:0];
        end
    end

    assign w_sum = (72'(r_v00) <<< 32) + ((72'(r_q1) + 72'(r_q2)) <<< 16) + 72'(r_q3);
    assign w_mag = r_s[32] ? 33'(-r_s) : 33'(r_s);
    assign w_p32 = r_prod[47:16];
    assign w_cols = (i_cfg.grid_cols == 7'd0) ? 7'd1 : i_cfg.grid_cols;

    always_comb begin
        case (r_rcnt)
            3'd0:    begin w_row = r_y0; w_col = r_x0; end
            3'd1:    begin w_row = r_y0; w_col = r_x1; end
            3'd2:    begin w_row = r_y1; w_col = r_x0; end
            default: begin w_row = r_y1; w_col = r_x1; end
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_FX;
            r_wb    <= 1'b0;
            r_rcnt  <= 3'd0;
            r_rph   <= 1'b0;
            r_empty <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_empty <= i_empty;
                        r_op    <= OP_FX;
                        r_wb    <= 1'b0;
                        r_state <= i_empty ? S_DONE : S_MUL;
                    end
                end
                S_MUL: begin
                    r_wb <= ~r_wb;
                    if (r_wb) begin
                        r_op <= r_op + 5'd1;
                        if (r_op == OP_IDX) begin
                            r_state <= S_READ;
                            r_rcnt  <= 3'd0;
                            r_rph   <= 1'b0;
                        end else if (r_op == OP_PGY) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_READ: begin
                    r_rph <= ~r_rph;
                    if (r_rph) begin
                        r_rcnt <= r_rcnt + 3'd1;
                    end
                    if (!r_rph && r_rcnt == 3'd4) begin
                        r_state <= S_MUL;
                        r_wb    <= 1'b0;
                    end
                end
                S_DONE: begin
                    if (i_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_dx <= 33'(i_px) - 33'(i_cfg.origin_x);
            r_dy <= 33'(i_py) - 33'(i_cfg.origin_y);
        end
        if (r_state == S_READ) begin
            if (!r_rph) begin
                r_raw <= 14'(w_row) * 14'(w_cols) + 14'(w_col);
                case (r_rcnt)
                    3'd1:    r_v00 <= i_rd_data;
                    3'd2:    r_v01 <= i_rd_data;
                    3'd3:    r_v10 <= i_rd_data;
                    3'd4:    r_v11 <= i_rd_data;
                    default: ;
                endcase
            end
        end
        if (r_state == S_MUL) begin
            if (!r_wb) begin
                r_prod <= m_a * m_b;
            end else begin
                case (r_op)
                    OP_FX:   r_fx <= w_cap - 42'sd32768;
                    OP_FY:   r_fy <= w_cap - 42'sd32768;
                    OP_IDX: begin
                        r_tx <= r_fx[15:0];
                        r_ty <= r_fy[15:0];
                        r_x0 <= clamp_idx(27'($signed(r_fx[41:16])), i_cfg.grid_cols);
                        r_x1 <= clamp_idx(27'($signed(r_fx[41:16])) + 27'sd1,
                                          i_cfg.grid_cols);
                        r_y0 <= clamp_idx(27'($signed(r_fy[41:16])), i_cfg.grid_rows);
                        r_y1 <= clamp_idx(27'($signed(r_fy[41:16])) + 27'sd1,
                                          i_cfg.grid_rows);
                    end
                    OP_DIF: begin
                        r_d0 <= 33'(r_v01) - 33'(r_v00);
                        r_e0 <= 33'(r_v10) - 33'(r_v00);
                        r_dd <= 34'(r_v11) - 34'(r_v10) - 34'(r_v01) + 34'(r_v00);
                    end
                    OP_TXY:  r_txy  <= r_prod[31:0];
                    OP_Q1:   r_q1   <= r_prod[48:0];
                    OP_Q2:   r_q2   <= r_prod[48:0];
                    OP_Q3:   r_q3   <= r_prod[65:0];
                    OP_MIXX: r_mixx <= 34'(r_d0) + w_q16[33:0];
                    OP_MIXY: r_mixy <= 34'(r_e0) + w_q16[33:0];
                    OP_VAL:  r_val  <= sat32(68'(w_sum >>> 32));
                    OP_GX:   r_gx   <= sat32(w_q16);
                    OP_GY:   r_gy   <= sat32(w_q16);
                    OP_S: begin
                        r_s    <= 33'(r_val) - 33'(i_cfg.clearance);
                        r_safe <= (33'(r_val) - 33'(i_cfg.clearance)) >= 0;
                    end
                    OP_PEN: begin
                        if (r_safe) begin
                            r_pen <= '0;
                        end else if ((|w_mag[32:24]) || w_p32[31]) begin
                            r_pen <= 31'h7FFF_FFFF;
                        end else begin
                            r_pen <= w_p32[30:0];
                        end
                    end
                    OP_PGX:  r_pgx <= r_safe ? 32'sd0 : sat32(r_prod >>> 15);
                    OP_PGY:  r_pgy <= r_safe ? 32'sd0 : sat32(r_prod >>> 15);
                    default: ;
                endcase
            end
        end
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_done    = (r_state == S_DONE);
    assign o_rd_en   = (r_state == S_READ) && r_rph;
    assign o_rd_addr = wrap_addr(r_raw);

    always_comb begin
        if (r_empty) begin
            o_res            = '0;
            o_res.grid_empty = 1'b1;
        end else begin
            o_res.distance_value = r_val;
            o_res.gradient_x     = r_gx;
            o_res.gradient_y     = r_gy;
            o_res.is_safe        = r_safe;
            o_res.penalty        = r_pen;
            o_res.penalty_grad_x = r_pgx;
            o_res.penalty_grad_y = r_pgy;
            o_res.grid_empty     = 1'b0;
        end
    end
endmodule

FILE: dv/sdfq_checker.sv
// result checker for the signed distance grid query block: watches the
// stream and configuration ports, predicts every query result and compares
// depends on sdfq_pkg
module sdfq_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_valid,
    input  logic         i_s_ready,
    input  logic [111:0] i_s_data,
    input  logic         i_s_user,
    input  logic         i_m_valid,
    input  logic         i_m_ready,
    input  logic [191:0] i_m_data,
    input  logic         i_m_user,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_wdata,
    output int           o_errors,
    output int           o_pending
);
    import sdfq_pkg::*;

    localparam int      CELLS = 4096;
    localparam longint  ONE_Q = 65536;
    localparam longint  CAP   = 64'sd1 << 40;

    t_cfg        cfg;
    logic [31:0] grid_mem [CELLS];
    bit          loaded;
    t_res        expected_q [$];

    function automatic logic [63:0] magnitude(longint a);
        return a < 0 ? 64'd0 - 64'(a) : 64'(a);
    endfunction

    // floor(a*b / 2^sh), magnitude capped at 2^40
    function automatic longint scaled_product(longint a, longint b, int sh);
        bit          neg;
        logic [63:0] p;
        logic [63:0] q;
        neg = (a < 0) != (b < 0);
        p = magnitude(a) * magnitude(b);
        q = p >> sh;
        if (neg && (p & ((64'd1 << sh) - 64'd1)) != 0) q++;
        if (q > 64'(CAP)) q = 64'(CAP);
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clamp_index(longint i, longint n);
        longint hi;
        hi = (n == 0) ? 0 : n - 1;
        if (i < 0) return 0;
        if (i > hi) return hi;
        return i;
    endfunction

    function automatic longint cell_at(longint r, longint c);
        longint cols;
        cols = (cfg.grid_cols == 0) ? 1 : longint'(cfg.grid_cols);
        return longint'($signed(grid_mem[(r * cols + c) % CELLS]));
    endfunction

    function automatic t_res predict_query(longint px, longint py);
        t_res   r;
        longint inv, fx, fy, tx, ty, x0, y0, x1, y1;
        longint v00, v01, v10, v11, sum, val, mix, gx, gy, s, pen, pgx, pgy;
        logic [63:0] m;
        r = '0;
        if (!loaded) begin
            r.grid_empty = 1'b1;
            return r;
        end
        inv = longint'(cfg.inv_cell_size);
        fx = scaled_product(px - longint'(cfg.origin_x), inv, 16) - 32768;
        fy = scaled_product(py - longint'(cfg.origin_y), inv, 16) - 32768;
        tx = fx & 64'hFFFF;
        ty = fy & 64'hFFFF;
        x0 = fx >>> 16;
        y0 = fy >>> 16;
        x1 = clamp_index(x0 + 1, longint'(cfg.grid_cols));
        y1 = clamp_index(y0 + 1, longint'(cfg.grid_rows));
        x0 = clamp_index(x0, longint'(cfg.grid_cols));
        y0 = clamp_index(y0, longint'(cfg.grid_rows));
        v00 = cell_at(y0, x0);
        v01 = cell_at(y0, x1);
        v10 = cell_at(y1, x0);
        v11 = cell_at(y1, x1);
        sum = (ONE_Q - ty) * (ONE_Q - tx) * v00 + (ONE_Q - ty) * tx * v01
            + ty * (ONE_Q - tx) * v10 + ty * tx * v11;
        val = clip32(sum >>> 32);
        mix = ((ONE_Q - ty) * (v01 - v00) + ty * (v11 - v10)) >>> 16;
        gx = clip32(scaled_product(mix, inv, 16));
        mix = ((ONE_Q - tx) * (v10 - v00) + tx * (v11 - v01)) >>> 16;
        gy = clip32(scaled_product(mix, inv, 16));
        s = val - longint'(cfg.clearance);
        pen = 0;
        pgx = 0;
        pgy = 0;
        if (s < 0) begin
            m = magnitude(s);
            if (m >= (64'd1 << 24)) begin
                pen = 64'sd2147483647;
            end else begin
                pen = longint'((m * m) >> 16);
                if (pen > 64'sd2147483647) pen = 64'sd2147483647;
            end
            pgx = clip32(scaled_product(s, gx, 15));
            pgy = clip32(scaled_product(s, gy, 15));
        end
        r.distance_value = val[31:0];
        r.gradient_x     = gx[31:0];
        r.gradient_y     = gy[31:0];
        r.is_safe        = (s >= 0);
        r.penalty        = pen[30:0];
        r.penalty_grad_x = pgx[31:0];
        r.penalty_grad_y = pgy[31:0];
        return r;
    endfunction

    task automatic compare_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;
        t_res got;
        if (!i_rst_n) begin
            cfg.origin_x      <= '0;
            cfg.origin_y      <= '0;
            cfg.inv_cell_size <= 32'd65536;
            cfg.clearance     <= '0;
            cfg.grid_rows     <= 7'd64;
            cfg.grid_cols     <= 7'd64;
            loaded            <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_ORIGIN_X:  cfg.origin_x <= i_cfg_wdata;
                    REG_ORIGIN_Y:  cfg.origin_y <= i_cfg_wdata;
                    REG_INV_CELL:  cfg.inv_cell_size <= i_cfg_wdata;
                    REG_CLEARANCE: cfg.clearance <= i_cfg_wdata;
                    REG_GRID_ROWS: cfg.grid_rows <= i_cfg_wdata[6:0];
                    REG_GRID_COLS: cfg.grid_cols <= i_cfg_wdata[6:0];
                    default: ;
                endcase
            end
            if (i_m_valid && i_m_ready) begin
                got.distance_value = i_m_data[31:0];
                got.gradient_x     = i_m_data[63:32];
                got.gradient_y     = i_m_data[95:64];
                got.is_safe        = i_m_data[96];
                got.penalty        = i_m_data[127:97];
                got.penalty_grad_x = i_m_data[159:128];
                got.penalty_grad_y = i_m_data[191:160];
                got.grid_empty     = i_m_user;
                if (expected_q.size() == 0) begin
                    $error("result beat with no query outstanding");
                    o_errors++;
                end else begin
                    want = expected_q.pop_front();
                    compare_field("distance_value", want.distance_value, got.distance_value);
                    compare_field("gradient_x", want.gradient_x, got.gradient_x);
                    compare_field("gradient_y", want.gradient_y, got.gradient_y);
                    compare_field("is_safe", want.is_safe, got.is_safe);
                    compare_field("penalty", want.penalty, got.penalty);
                    compare_field("penalty_grad_x", want.penalty_grad_x, got.penalty_grad_x);
                    compare_field("penalty_grad_y", want.penalty_grad_y, got.penalty_grad_y);
                    compare_field("grid_empty", want.grid_empty, got.grid_empty);
                end
            end
            if (i_s_valid && i_s_ready) begin
                if (i_s_user == CMD_WRITE) begin
                    grid_mem[i_s_data[11:0]] <= i_s_data[43:12];
                    loaded <= 1'b1;
                end else begin
                    expected_q = {expected_q, predict_query(
                        longint'($signed(i_s_data[75:44])),
                        longint'($signed(i_s_data[107:76])))};
                end
            end
            o_pending <= expected_q.size();
        end
    end

endmodule

FILE: dv/testbench.sv
// top of the signed distance grid query testbench: clock, reset, stimulus,
// receiver backpressure and the verdict
// depends on sdfq_pkg, sdfq_checker and the block under test
module testbench;
    import sdfq_pkg::*;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [191:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         i_cfg_we;
    logic [2:0]   i_cfg_addr;
    logic [31:0]  i_cfg_wdata;
    int           errors;
    int           pending;

    int           tx_idle_pct;
    int           rx_idle_pct;
    bit           stall_req;
    bit           stall_seen;
    int           stall_left;

    longint       cur_ox, cur_oy, cur_inv;
    int           cur_rows, cur_cols;

    sdf_grid_bilinear_query dut (.*);

    sdfq_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_valid(s_axis_tvalid), .i_s_ready(s_axis_tready),
        .i_s_data(s_axis_tdata), .i_s_user(s_axis_tuser),
        .i_m_valid(m_axis_tvalid), .i_m_ready(m_axis_tready),
        .i_m_data(m_axis_tdata), .i_m_user(m_axis_tuser),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata),
        .o_errors(errors), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // receiver: random stalls plus one long hold-off on request
    always @(posedge i_clk) begin
        if (stall_req != stall_seen) begin
            stall_seen <= stall_req;
            stall_left <= 400;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_beat(logic cmd, logic [11:0] idx, logic [31:0] value,
                             logic [31:0] px, logic [31:0] py);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'b0, py, px, value, idx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        case (addr)
            REG_ORIGIN_X:  cur_ox = longint'($signed(value));
            REG_ORIGIN_Y:  cur_oy = longint'($signed(value));
            REG_INV_CELL:  cur_inv = longint'(value);
            REG_GRID_ROWS: cur_rows = value;
            REG_GRID_COLS: cur_cols = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // point near the grid in use, now and then anywhere
    function automatic logic [31:0] pick_coord(longint origin, int n);
        longint span, p;
        if ($urandom_range(99) < 15) return $urandom;
        span = ((n + 2) * (64'sd1 << 32)) / cur_inv;
        if (span > 64'sd4294967295) span = 64'sd4294967295;
        p = origin - (64'sd1 << 32) / cur_inv + longint'($urandom) % (span + 1);
        if (p > 64'sd2147483647) p = 64'sd2147483647;
        if (p < -64'sd2147483648) p = -64'sd2147483648;
        return p[31:0];
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            default: return $urandom_range(8 << 16) - (4 << 16);
        endcase
    endfunction

    task automatic query(logic [31:0] px, logic [31:0] py);
        send_beat(CMD_QUERY, 12'($urandom), $urandom, px, py);
    endtask

    task automatic random_phase(int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < 30)
                send_beat(CMD_WRITE, 12'($urandom), pick_value(), $urandom, $urandom);
            else
                query(pick_coord(cur_ox, cur_cols), pick_coord(cur_oy, cur_rows));
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_WRITE;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = REG_ORIGIN_X;
        i_cfg_wdata   = '0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        stall_req     = 1'b0;
        cur_ox = 0; cur_oy = 0; cur_inv = 65536; cur_rows = 64; cur_cols = 64;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty grid, then load every cell that a query below can reach
        query(32'h0001_0000, 32'h0001_0000);
        for (int c = 0; c < 64; c++)
            send_beat(CMD_WRITE, c[11:0], pick_value(), $urandom, $urandom);
        send_beat(CMD_WRITE, 12'd0, 32'h8000_0000, '0, '0);
        send_beat(CMD_WRITE, 12'd1, 32'h7FFF_FFFF, '0, '0);
        send_beat(CMD_WRITE, 12'd64, 32'h7FFF_FFFF, '0, '0);
        send_beat(CMD_WRITE, 12'd65, 32'h8000_0000, '0, '0);
        send_beat(CMD_WRITE, 12'hFC0, pick_value(), '0, '0);
        send_beat(CMD_WRITE, 12'hFFF, 32'hFFFF_FFFF, '0, '0);
        query(32'h0000_0000, 32'h0000_0000);
        query(32'h0000_8000, 32'h0000_8000);
        query(32'h0001_0000, 32'h0000_C000);
        query(32'h8000_0000, 32'h8000_0000);
        query(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        query(32'h7FFF_FFFF, 32'h8000_0000);
        query(32'h003F_8000, 32'h003F_8000);
        drain_results();

        // extremes of every register
        write_reg(REG_ORIGIN_X, 32'h8000_0000);
        write_reg(REG_ORIGIN_Y, 32'h7FFF_FFFF);
        write_reg(REG_INV_CELL, 32'd1);
        write_reg(REG_CLEARANCE, 32'h7FFF_FFFF);
        write_reg(REG_GRID_ROWS, 32'd2);
        write_reg(REG_GRID_COLS, 32'd2);
        i_cfg_we <= 1'b0;
        query(32'h8000_0000, 32'h7FFF_FFFF);
        query(32'h7FFF_FFFF, 32'h8000_0000);
        query(32'h0000_0000, 32'h0000_0000);
        drain_results();
        write_reg(REG_ORIGIN_X, 32'h0);
        write_reg(REG_ORIGIN_Y, 32'h0);
        write_reg(REG_INV_CELL, 32'hFFFF_FFFF);
        write_reg(REG_CLEARANCE, 32'h8000_0000);
        write_reg(REG_GRID_ROWS, 32'd64);
        write_reg(REG_GRID_COLS, 32'd64);
        i_cfg_we <= 1'b0;
        query(32'h0000_0100, 32'h0000_0000);
        query(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        query(32'h8000_0000, 32'h0000_0300);
        drain_results();

        // grids up to 8 by 8 only read the first 64 cells
        for (int ph = 0; ph < 6; ph++) begin
            tx_idle_pct = (ph < 2) ? 32 : (ph < 4) ? 67 : 0;
            rx_idle_pct = (ph < 2) ? 67 : (ph < 4) ? 32 : 0;
            write_reg(REG_ORIGIN_X, $urandom_range(1 << 24) - (1 << 23));
            write_reg(REG_ORIGIN_Y, $urandom_range(1 << 24) - (1 << 23));
            write_reg(REG_INV_CELL, $urandom_range(1 << 20, 1 << 13));
            write_reg(REG_CLEARANCE, $urandom_range(4 << 16) - (1 << 16));
            write_reg(REG_GRID_ROWS, $urandom_range(8, 2));
            write_reg(REG_GRID_COLS, $urandom_range(8, 2));
            i_cfg_we <= 1'b0;
            if (ph == 4) stall_req = ~stall_req;
            random_phase(35);
            if (ph == 2) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            random_phase(35);
            drain_results();
        end

        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
